// File: design/i2a_pkg.sv
package i2a_pkg;

	localparam int VALUE_W   = 64;
	localparam int RADIX_W   = 5;
	localparam int FW_W      = 7;
	localparam int CHAR_W    = 7;
	localparam int MAX_CHARS = 64;

	localparam int STEP_W    = 8;
	localparam int STEPS     = VALUE_W / STEP_W;
	localparam int IDX_W     = $clog2(STEPS);

	localparam int DIGIT_W   = 4;
	localparam int DIG_DEPTH = VALUE_W;
	localparam int DADDR_W   = $clog2(DIG_DEPTH);
	localparam int ND_W      = $clog2(DIG_DEPTH + 1);
	localparam int CNT_W     = $clog2(MAX_CHARS + 1);
	localparam int POS_W     = 8;
	localparam int SZ_W      = FW_W + 2;

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
	localparam logic [RADIX_W-1:0] RADIX_BIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
	localparam logic [CHAR_W-1:0] CH_UP_B  = 7'h42;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 7'h58;
	localparam logic [CHAR_W-1:0] CH_LOWER = 7'h20;

	typedef struct packed {
		logic start;
		logic load;
	} div_cmd_t;

	typedef struct packed {
		logic               done;
		logic               zero;
		logic [DIGIT_W-1:0] digit;
	} div_sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic lc);
		logic [CHAR_W-1:0] ch;
		if (d < DIGIT_W'(10)) begin
			ch = CH_ZERO + CHAR_W'(d);
		end else begin
			ch = (CH_UP_A + CHAR_W'(d) - CHAR_W'(10)) | (lc ? CH_LOWER : '0);
		end
		return ch;
	endfunction

endpackage

// File: design/i2a_ram.sv
module i2a_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/i2a_div.sv
module i2a_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  i2a_pkg::div_cmd_t              cmd,
	input  logic [i2a_pkg::VALUE_W-1:0]    operand,
	input  logic [i2a_pkg::RADIX_W-1:0]    radix,
	output i2a_pkg::div_sts_t              sts
);

	logic [i2a_pkg::VALUE_W-1:0] val_q;
	logic [i2a_pkg::IDX_W-1:0]   idx_q;
	logic [i2a_pkg::DIGIT_W-1:0] rem_q;
	logic                        run_q;
	logic                        done_q;

	logic [i2a_pkg::VALUE_W-1:0] src;
	logic [i2a_pkg::IDX_W-1:0]   top_idx;
	logic [i2a_pkg::STEP_W-1:0]  byte_in;
	logic [i2a_pkg::STEP_W-1:0]  qbyte;
	logic [i2a_pkg::RADIX_W-1:0] r;

	always_comb begin
		src = cmd.load ? operand : val_q;
		top_idx = '0;
		for (int i = 0; i < i2a_pkg::STEPS; i++) begin
			if (src[i*i2a_pkg::STEP_W +: i2a_pkg::STEP_W] != '0) begin
				top_idx = i2a_pkg::IDX_W'(i);
			end
		end
	end

	// one quotient byte per cycle, restoring steps on the narrow remainder
	always_comb begin
		byte_in = val_q[idx_q*i2a_pkg::STEP_W +: i2a_pkg::STEP_W];
		r = i2a_pkg::RADIX_W'(rem_q);
		qbyte = '0;
		for (int j = i2a_pkg::STEP_W - 1; j >= 0; j--) begin
			r = {r[i2a_pkg::RADIX_W-2:0], byte_in[j]};
			if (r >= radix) begin
				r = r - radix;
				qbyte[j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			if (idx_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q <= src;
			idx_q <= top_idx;
			rem_q <= '0;
		end else if (run_q) begin
			val_q[idx_q*i2a_pkg::STEP_W +: i2a_pkg::STEP_W] <= qbyte;
			rem_q <= r[i2a_pkg::DIGIT_W-1:0];
			if (idx_q != '0) begin
				idx_q <= idx_q - i2a_pkg::IDX_W'(1);
			end
		end
	end

	assign sts.done  = done_q;
	assign sts.zero  = (val_q == '0);
	assign sts.digit = rem_q;

endmodule

// File: design/integer_to_ascii_formatter.sv
// Conversion: each digit is one divider pass over the bytes of the running quotient, from
// its highest nonzero byte down; the field is then sized in ST_PAD and ST_BND before
// output starts.
// Throughput: then one character per cycle unless out_ready stalls the output, at most
// 64 per item; the next item is taken once the last character is in the output register.
// Reset: arst_n clears the sequencer and output valid asynchronously; ready after reset.
module integer_to_ascii_formatter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [i2a_pkg::VALUE_W-1:0]     value,
	input  logic [i2a_pkg::RADIX_W-1:0]     radix,
	input  logic [i2a_pkg::FW_W-1:0]        min_width,
	input  logic [i2a_pkg::FW_W-1:0]        min_digits,
	input  logic                            left_justify,
	input  logic                            force_plus,
	input  logic                            space_sign,
	input  logic                            alt_prefix,
	input  logic                            zero_pad,
	input  logic                            lower_case,
	input  logic                            is_signed,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [i2a_pkg::CHAR_W-1:0]      char_out,
	output logic                            last_char,
	output logic                            truncated
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_PAD  = 5'b00100,
		ST_BND  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	localparam int POS_W = i2a_pkg::POS_W;
	localparam int FW_W  = i2a_pkg::FW_W;
	localparam int CNT_W = i2a_pkg::CNT_W;
	localparam int SZ_W  = i2a_pkg::SZ_W;

	state_t state_q, state_d;

	logic [i2a_pkg::RADIX_W-1:0] radix_q;
	logic [FW_W-1:0]             fw_q;
	logic [FW_W-1:0]             md_q;
	logic                        left_q;
	logic                        zp_q;
	logic                        alt_q;
	logic                        lc_q;
	logic                        sgn_q;
	logic [i2a_pkg::CHAR_W-1:0]  sgn_ch_q;
	logic [i2a_pkg::ND_W-1:0]    nd_q;
	logic [FW_W-1:0]             prec_q;
	logic [FW_W-1:0]             pad_q;
	logic [POS_W-1:0]            b1_q, b2_q, b3_q, b5_q, b6_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        over_q;
	logic [CNT_W-1:0]            k_q;
	logic [i2a_pkg::DADDR_W-1:0] dptr_q, dptr_d;

	logic                        out_valid_q;
	logic [i2a_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;
	logic                        trunc_q;

	logic                        in_beat;
	logic                        radix_ok;
	logic                        neg;
	logic [i2a_pkg::VALUE_W-1:0] mag;
	i2a_pkg::div_cmd_t           div_cmd;
	i2a_pkg::div_sts_t           div_sts;
	logic                        dig_we;
	logic [i2a_pkg::DIGIT_W-1:0] rd_digit;

	logic                        p8;
	logic [FW_W-1:0]             prec;
	logic [SZ_W-1:0]             sz;
	logic [FW_W-1:0]             pad;
	logic [POS_W-1:0]            pref_n, lead_n, zpad_n, trail_n, zeros_n;
	logic [POS_W-1:0]            c1, c2, c3, c4, c5, c6, total;

	logic                        load;
	logic [POS_W-1:0]            kx;
	logic                        in_dig;
	logic                        is_last;
	logic [CNT_W-1:0]            k_nx;
	logic [i2a_pkg::CHAR_W-1:0]  ch;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign radix_ok = radix inside {[i2a_pkg::RADIX_MIN:i2a_pkg::RADIX_MAX]};
	assign neg      = is_signed && value[i2a_pkg::VALUE_W-1];
	assign mag      = neg ? (~value + i2a_pkg::VALUE_W'(1)) : value;

	assign div_cmd.load  = in_beat;
	assign div_cmd.start = (in_beat && radix_ok) ||
		((state_q == ST_CONV) && div_sts.done && !div_sts.zero);
	assign dig_we = (state_q == ST_CONV) && div_sts.done;

	i2a_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (div_cmd),
		.operand (mag),
		.radix   (radix_q),
		.sts     (div_sts)
	);

	i2a_ram #(
		.WIDTH (i2a_pkg::DIGIT_W),
		.DEPTH (i2a_pkg::DIG_DEPTH)
	) u_digits (
		.clk   (clk),
		.we    (dig_we),
		.waddr (nd_q[i2a_pkg::DADDR_W-1:0]),
		.wdata (div_sts.digit),
		.raddr (dptr_d),
		.rdata (rd_digit)
	);

	// field sizing
	always_comb begin
		p8   = alt_q && (radix_q == i2a_pkg::RADIX_OCT);
		prec = (FW_W'(nd_q) > md_q) ? FW_W'(nd_q) : md_q;
		sz   = SZ_W'(fw_q) - SZ_W'(sgn_q) - SZ_W'(p8) - SZ_W'(prec);
		pad  = (!sz[SZ_W-1] && (sz != '0)) ? sz[FW_W-1:0] : '0;
	end

	// segment boundaries
	always_comb begin
		if (!alt_q) begin
			pref_n = '0;
		end else if (radix_q == i2a_pkg::RADIX_OCT) begin
			pref_n = POS_W'(1);
		end else if (radix_q == i2a_pkg::RADIX_BIN || radix_q == i2a_pkg::RADIX_HEX) begin
			pref_n = POS_W'(2);
		end else begin
			pref_n = '0;
		end
		lead_n  = (!zp_q && !left_q) ? POS_W'(pad_q) : '0;
		zpad_n  = zp_q ? POS_W'(pad_q) : '0;
		trail_n = left_q ? POS_W'(pad_q) : '0;
		zeros_n = POS_W'(prec_q) - POS_W'(nd_q);
		c1      = lead_n;
		c2      = c1 + POS_W'(sgn_q);
		c3      = c2 + pref_n;
		c4      = c3 + zpad_n;
		c5      = c4 + zeros_n;
		c6      = c5 + POS_W'(nd_q);
		total   = c6 + trail_n;
	end

	// character at the current position
	always_comb begin
		load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		kx      = POS_W'(k_q);
		in_dig  = (kx >= b5_q) && (kx < b6_q);
		k_nx    = k_q + CNT_W'(1);
		is_last = (k_nx == cnt_q);
		if (kx < b1_q) begin
			ch = i2a_pkg::CH_SPACE;
		end else if (kx < b2_q) begin
			ch = sgn_ch_q;
		end else if (kx < b3_q) begin
			if (kx == b2_q) begin
				ch = i2a_pkg::CH_ZERO;
			end else begin
				ch = ((radix_q == i2a_pkg::RADIX_HEX) ? i2a_pkg::CH_UP_X : i2a_pkg::CH_UP_B) |
					(lc_q ? i2a_pkg::CH_LOWER : '0);
			end
		end else if (kx < b5_q) begin
			ch = i2a_pkg::CH_ZERO;
		end else if (in_dig) begin
			ch = i2a_pkg::digit_char(rd_digit, lc_q);
		end else begin
			ch = i2a_pkg::CH_SPACE;
		end
	end

	// read address leads the pointer so the digit is ready when needed
	always_comb begin
		if (state_q == ST_PAD || state_q == ST_BND) begin
			dptr_d = i2a_pkg::DADDR_W'(nd_q - i2a_pkg::ND_W'(1));
		end else if (load && in_dig) begin
			dptr_d = dptr_q - i2a_pkg::DADDR_W'(1);
		end else begin
			dptr_d = dptr_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat && radix_ok) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (div_sts.done && div_sts.zero) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				state_d = ST_BND;
			end
			ST_BND: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			radix_q <= radix;
			fw_q    <= min_width;
			md_q    <= min_digits;
			left_q  <= left_justify;
			zp_q    <= zero_pad && !left_justify;
			alt_q   <= alt_prefix;
			lc_q    <= lower_case;
			sgn_q   <= is_signed && (neg || force_plus || space_sign);
			if (neg) begin
				sgn_ch_q <= i2a_pkg::CH_MINUS;
			end else if (force_plus) begin
				sgn_ch_q <= i2a_pkg::CH_PLUS;
			end else begin
				sgn_ch_q <= i2a_pkg::CH_SPACE;
			end
			nd_q <= '0;
		end else if (dig_we) begin
			nd_q <= nd_q + i2a_pkg::ND_W'(1);
		end
		if (state_q == ST_PAD) begin
			prec_q <= prec;
			pad_q  <= pad;
		end
		if (state_q == ST_BND) begin
			b1_q   <= c1;
			b2_q   <= c2;
			b3_q   <= c3;
			b5_q   <= c5;
			b6_q   <= c6;
			over_q <= (total > POS_W'(i2a_pkg::MAX_CHARS));
			cnt_q  <= (total > POS_W'(i2a_pkg::MAX_CHARS)) ?
				CNT_W'(i2a_pkg::MAX_CHARS) : CNT_W'(total);
			k_q    <= '0;
		end else if (load) begin
			k_q <= k_nx;
		end
		dptr_q <= dptr_d;
		if (load) begin
			char_q  <= ch;
			last_q  <= is_last;
			trunc_q <= is_last && over_q;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last_char = last_q;
	assign truncated = trunc_q;

endmodule
